FILE: sv/cppl_pkg.sv
// Shared types and codes for the convex polygon point location block.
// No dependencies; used by convex_polygon_point_location.
`timescale 1ns / 1ps
`default_nettype none

package cppl_pkg;

    localparam int COORD_W = 29;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vertex;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] LOC_INSIDE     = 2'd0;
    localparam logic [1:0] LOC_BORDER     = 2'd1;
    localparam logic [1:0] LOC_OUTSIDE    = 2'd2;
    localparam logic [1:0] LOC_NOT_CONVEX = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVEX,
        ST_LOCATE
    } t_state;

    // Position of a point against a directed edge.
    typedef enum logic [1:0] {
        SIDE_LEFT,
        SIDE_RIGHT,
        SIDE_ON,
        SIDE_OFF
    } t_side;

endpackage

`default_nettype wire

FILE: sv/convex_polygon_point_location.sv
// Convex polygon point location: vertex memory, edge walker and cross-product pipeline.
// Depends on cppl_pkg.
// A load writes one vertex while idle. A query over n vertices makes n + 2 reads for the
// convexity pass and n + 1 for the edge pass, each followed by a four-stage read and
// multiply pipeline, and ends early once an edge settles the answer. Busy holds the next
// request off until the result strobe, so queries never overlap.
// Reset clears control state and sets vertex_count to 3; the vertex memory is not cleared.
// The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module convex_polygon_point_location #(
    parameter int MAX_VERTICES = 64
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire                     i_opcode,
    input  wire  [5:0]              i_vertex_index,
    input  wire  signed [28:0]      i_coord_x,
    input  wire  signed [28:0]      i_coord_y,
    output logic                    o_location_valid,
    output logic [1:0]              o_location,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [6:0]              i_cfg_data
);

    localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int CW1 = CW + 1;

    // Vertex memory. Writes happen only while idle and reads only while busy,
    // so the two ports never touch the same entry in the same cycle.
    cppl_pkg::t_vertex mem [MAX_VERTICES];

    cppl_pkg::t_state r_state, n_state;
    logic [6:0]       r_vertex_count;
    logic [CW-1:0]    r_used_cnt;
    logic [CW-1:0]    r_res_cnt;
    logic [IW-1:0]    r_rd_addr;
    logic [CW1-1:0]   r_rd_left;
    logic             r_rvld;
    logic [1:0]       r_fill;
    logic             r_wv;
    logic             r_e0v;
    logic             r_e1v;
    logic             r_out_vld;
    logic [1:0]       r_loc;

    cppl_pkg::t_vertex r_rdata;
    cppl_pkg::t_vertex r_wa, r_wb, r_wc;
    cppl_pkg::t_coord  r_px, r_py;
    cppl_pkg::t_diff   r_dx1, r_dy1, r_dx2, r_dy2;
    logic              r_box0, r_box1;
    cppl_pkg::t_prod   r_p1, r_p2;

    logic              query_go, load_go, idx_ok;
    logic [CW-1:0]     clamped_cnt;
    logic [CW1-1:0]    addr_inc;
    logic [IW-1:0]     addr_next;
    logic              rd_en, res_last, finish, to_locate, flush, win_full;
    logic [1:0]        fin_code;
    logic              in_box;
    cppl_pkg::t_side   side;
    logic [1:0]        fill_need;

    assign query_go = start && !busy && (i_opcode == cppl_pkg::OP_QUERY);
    assign load_go  = start && !busy && (i_opcode == cppl_pkg::OP_LOAD);
    assign idx_ok   = 32'(i_vertex_index) < 32'(MAX_VERTICES);

    always_comb begin
        if (r_vertex_count < 7'd3) begin
            clamped_cnt = CW'(3);
        end else if (32'(r_vertex_count) > 32'(MAX_VERTICES)) begin
            clamped_cnt = CW'(MAX_VERTICES);
        end else begin
            clamped_cnt = CW'(r_vertex_count);
        end
    end

    // Addresses wrap around the vertices in use.
    assign addr_inc  = CW1'(r_rd_addr) + CW1'(1);
    assign addr_next = (addr_inc >= CW1'(r_used_cnt)) ? '0 : IW'(addr_inc);
    assign res_last  = (CW1'(r_res_cnt) + CW1'(1)) == CW1'(r_used_cnt);

    // Bounding box of edge (a, b) against c, on the window registers.
    always_comb begin
        logic signed [28:0] xl, xh, yl, yh;
        xl = (r_wa.x < r_wb.x) ? r_wa.x : r_wb.x;
        xh = (r_wa.x < r_wb.x) ? r_wb.x : r_wa.x;
        yl = (r_wa.y < r_wb.y) ? r_wa.y : r_wb.y;
        yh = (r_wa.y < r_wb.y) ? r_wb.y : r_wa.y;
        in_box = (r_wc.x >= xl) && (r_wc.x <= xh) && (r_wc.y >= yl) && (r_wc.y <= yh);
    end

    // The sign of d = p1 - p2 comes from comparing the two products.
    always_comb begin
        if (r_p1 > r_p2) begin
            side = cppl_pkg::SIDE_LEFT;
        end else if (r_p1 < r_p2) begin
            side = cppl_pkg::SIDE_RIGHT;
        end else if (r_box1) begin
            side = cppl_pkg::SIDE_ON;
        end else begin
            side = cppl_pkg::SIDE_OFF;
        end
    end

    // Outputs of the sequencer.
    always_comb begin
        finish    = 1'b0;
        to_locate = 1'b0;
        fin_code  = cppl_pkg::LOC_INSIDE;
        busy      = (r_state != cppl_pkg::ST_IDLE);
        rd_en     = (r_state != cppl_pkg::ST_IDLE) && (r_rd_left != '0);
        fill_need = (r_state == cppl_pkg::ST_CONVEX) ? 2'd2 : 2'd1;
        case (r_state)
            cppl_pkg::ST_CONVEX: begin
                if (r_e1v) begin
                    if (side == cppl_pkg::SIDE_RIGHT || side == cppl_pkg::SIDE_ON) begin
                        finish   = 1'b1;
                        fin_code = cppl_pkg::LOC_NOT_CONVEX;
                    end else if (res_last) begin
                        to_locate = 1'b1;
                    end
                end
            end
            cppl_pkg::ST_LOCATE: begin
                if (r_e1v) begin
                    if (side == cppl_pkg::SIDE_ON) begin
                        finish   = 1'b1;
                        fin_code = cppl_pkg::LOC_BORDER;
                    end else if (side != cppl_pkg::SIDE_LEFT) begin
                        finish   = 1'b1;
                        fin_code = cppl_pkg::LOC_OUTSIDE;
                    end else if (res_last) begin
                        finish   = 1'b1;
                        fin_code = cppl_pkg::LOC_INSIDE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign flush    = finish || to_locate;
    assign win_full = r_fill >= fill_need;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cppl_pkg::ST_IDLE: begin
                if (query_go) begin
                    n_state = cppl_pkg::ST_CONVEX;
                end
            end
            cppl_pkg::ST_CONVEX: begin
                if (finish) begin
                    n_state = cppl_pkg::ST_IDLE;
                end else if (to_locate) begin
                    n_state = cppl_pkg::ST_LOCATE;
                end
            end
            cppl_pkg::ST_LOCATE: begin
                if (finish) begin
                    n_state = cppl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cppl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= cppl_pkg::ST_IDLE;
            r_vertex_count <= 7'd3;
            r_used_cnt     <= CW'(3);
            r_res_cnt      <= '0;
            r_rd_addr      <= '0;
            r_rd_left      <= '0;
            r_rvld         <= 1'b0;
            r_fill         <= '0;
            r_wv           <= 1'b0;
            r_e0v          <= 1'b0;
            r_e1v          <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= finish;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_data;
            end
            if (query_go) begin
                r_used_cnt <= clamped_cnt;
            end

            // The convexity pass reads n + 2 vertices, the edge pass n + 1.
            if (query_go) begin
                r_rd_addr <= '0;
                r_rd_left <= CW1'(clamped_cnt) + CW1'(2);
            end else if (to_locate) begin
                r_rd_addr <= '0;
                r_rd_left <= CW1'(r_used_cnt) + CW1'(1);
            end else if (finish) begin
                r_rd_left <= '0;
            end else if (rd_en) begin
                r_rd_addr <= addr_next;
                r_rd_left <= r_rd_left - CW1'(1);
            end

            r_rvld <= rd_en && !flush;

            if (query_go || flush) begin
                r_fill <= '0;
            end else if (r_rvld && r_fill != 2'd3) begin
                r_fill <= r_fill + 2'd1;
            end

            r_wv  <= r_rvld && win_full && !flush;
            r_e0v <= r_wv && !flush;
            r_e1v <= r_e0v && !flush;

            if (query_go || to_locate) begin
                r_res_cnt <= '0;
            end else if (r_e1v) begin
                r_res_cnt <= r_res_cnt + CW'(1);
            end
        end
    end

    // Vertex memory ports.
    always_ff @(posedge i_clk) begin
        if (load_go && idx_ok) begin
            mem[IW'(i_vertex_index)] <= '{x: i_coord_x, y: i_coord_y};
        end
        if (rd_en) begin
            r_rdata <= mem[r_rd_addr];
        end
    end

    // Datapath: vertex window, differences, products.
    always_ff @(posedge i_clk) begin
        if (query_go) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (finish) begin
            r_loc <= fin_code;
        end

        // In the edge pass the third point is the query point.
        if (to_locate) begin
            r_wc <= '{x: r_px, y: r_py};
        end else if (r_rvld) begin
            r_wa <= r_wb;
            if (r_state == cppl_pkg::ST_CONVEX) begin
                r_wb <= r_wc;
                r_wc <= r_rdata;
            end else begin
                r_wb <= r_rdata;
            end
        end

        r_dx1  <= cppl_pkg::DIFF_W'(r_wb.x) - cppl_pkg::DIFF_W'(r_wa.x);
        r_dy1  <= cppl_pkg::DIFF_W'(r_wb.y) - cppl_pkg::DIFF_W'(r_wa.y);
        r_dx2  <= cppl_pkg::DIFF_W'(r_wc.x) - cppl_pkg::DIFF_W'(r_wa.x);
        r_dy2  <= cppl_pkg::DIFF_W'(r_wc.y) - cppl_pkg::DIFF_W'(r_wa.y);
        r_box0 <= in_box;

        r_p1   <= r_dx1 * r_dy2;
        r_p2   <= r_dx2 * r_dy1;
        r_box1 <= r_box0;
    end

    assign o_location_valid = r_out_vld;
    assign o_location       = r_loc;
    assign o_cfg_ready      = !busy;

endmodule

`default_nettype wire

FILE: tb/convex_polygon_point_location_test.sv
`timescale 1ns / 1ps
// Testbench for convex_polygon_point_location: loads polygons through the request port,
// queries points and checks every location code against an exact cross-product predictor.
// Depends on cppl_pkg and on the convex_polygon_point_location module.

module convex_polygon_point_location_test;

    localparam int     MAX_VERTICES  = 64;
    localparam int     ITEM_TARGET   = 950;
    localparam int     QUIET_TAIL    = 150;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     TAIL_CYCLES   = 2 * MAX_VERTICES + 60;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     PRINT_LIMIT   = 100;
    localparam longint C_MAX         = 268435455;
    localparam longint C_MIN         = -268435456;
    localparam real    TWO_PI        = 6.283185307179586;

    // Mirror of the vertex store and the vertex count, plus the location codes still owed.
    class location_scoreboard;
        longint     vertex_x[MAX_VERTICES];
        longint     vertex_y[MAX_VERTICES];
        bit [6:0]   vertex_count;
        logic [1:0] expected_codes[$];
        int         mismatches;

        function new();
            vertex_count = 7'd3;
            mismatches   = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: mismatch: %s", $time, what);
        endtask

        function void set_vertex_count(bit [6:0] value);
            vertex_count = value;
        endfunction

        function int used_vertices();
            if (vertex_count < 3)
                return 3;
            if (vertex_count > MAX_VERTICES)
                return MAX_VERTICES;
            return int'(vertex_count);
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        function cppl_pkg::t_side edge_side(longint ax, longint ay, longint bx, longint by,
                                            longint cx, longint cy);
            longint cross_prod;
            cross_prod = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
            if (cross_prod > 0)
                return cppl_pkg::SIDE_LEFT;
            if (cross_prod < 0)
                return cppl_pkg::SIDE_RIGHT;
            if (cx >= ((ax < bx) ? ax : bx) && cx <= ((ax < bx) ? bx : ax) &&
                cy >= ((ay < by) ? ay : by) && cy <= ((ay < by) ? by : ay))
                return cppl_pkg::SIDE_ON;
            return cppl_pkg::SIDE_OFF;
        endfunction

        function logic [1:0] predict_location(longint px, longint py);
            int              n;
            int              i;
            int              j;
            int              k;
            cppl_pkg::t_side s;
            n = used_vertices();
            for (i = 0; i < n; i++) begin
                j = (i + 1) % n;
                k = (j + 1) % n;
                s = edge_side(vertex_x[i], vertex_y[i], vertex_x[j], vertex_y[j],
                              vertex_x[k], vertex_y[k]);
                if (s == cppl_pkg::SIDE_RIGHT || s == cppl_pkg::SIDE_ON)
                    return cppl_pkg::LOC_NOT_CONVEX;
            end
            for (i = 0; i < n; i++) begin
                j = (i + 1) % n;
                s = edge_side(vertex_x[i], vertex_y[i], vertex_x[j], vertex_y[j], px, py);
                if (s == cppl_pkg::SIDE_ON)
                    return cppl_pkg::LOC_BORDER;
                if (s != cppl_pkg::SIDE_LEFT)
                    return cppl_pkg::LOC_OUTSIDE;
            end
            return cppl_pkg::LOC_INSIDE;
        endfunction

        function void note_request(logic op, logic [5:0] idx, cppl_pkg::t_coord x,
                                   cppl_pkg::t_coord y);
            if (op == cppl_pkg::OP_LOAD) begin
                vertex_x[idx] = longint'(x);
                vertex_y[idx] = longint'(y);
            end else begin
                expected_codes = {expected_codes, predict_location(longint'(x), longint'(y))};
            end
        endfunction

        task check_location(logic [1:0] got);
            logic [1:0] want;
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("location %0d with no query waiting", got));
            end else begin
                want = expected_codes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("location %0d, expected %0d", got, want));
            end
        endtask

        task check_drained();
            if (expected_codes.size() != 0)
                report_mismatch($sformatf("%0d query results never arrived",
                                          expected_codes.size()));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic             i_opcode       = cppl_pkg::OP_LOAD;
    logic [5:0]       i_vertex_index = '0;
    cppl_pkg::t_coord i_coord_x      = '0;
    cppl_pkg::t_coord i_coord_y      = '0;
    logic             o_location_valid;
    logic [1:0]       o_location;
    logic             i_cfg_valid    = 1'b0;
    logic             o_cfg_ready;
    logic [6:0]       i_cfg_data     = '0;

    longint             poly_x[MAX_VERTICES];
    longint             poly_y[MAX_VERTICES];
    longint             center_x;
    longint             center_y;
    int                 items_sent  = 0;
    int                 idle_pct    = 30;
    int                 cycle_count = 0;
    location_scoreboard sb;

    convex_polygon_point_location #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_vertex_index  (i_vertex_index),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .o_location_valid(o_location_valid),
        .o_location      (o_location),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint rand_coord();
        cppl_pkg::t_coord v;
        v = cppl_pkg::t_coord'($urandom);
        return longint'(v);
    endfunction

    function automatic longint rand_span(int unsigned lim);
        longint v;
        v = longint'($urandom_range(0, 2 * lim));
        return v - longint'(lim);
    endfunction

    function automatic logic [6:0] choose_count(int phase);
        int pick;
        case (phase)
            0: return 7'd127;
            1: return 7'd0;
            2: return 7'd64;
            3: return 7'd2;
            default: begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    return 7'($urandom_range(3, 12));
                if (pick < 95)
                    return 7'($urandom_range(13, 63));
                return $urandom_range(0, 1) ? 7'($urandom_range(0, 2))
                                            : 7'($urandom_range(64, 127));
            end
        endcase
    endfunction

    task automatic idle_burst();
        if (items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Start stays high from one request to the next unless an idle burst or settle_idle drops it.
    task automatic send_request(logic op, logic [5:0] idx, longint x, longint y);
        idle_burst();
        start          <= 1'b1;
        i_opcode       <= op;
        i_vertex_index <= idx;
        i_coord_x      <= cppl_pkg::t_coord'(x);
        i_coord_y      <= cppl_pkg::t_coord'(y);
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(op, idx, cppl_pkg::t_coord'(x), cppl_pkg::t_coord'(y));
        items_sent++;
    endtask

    // A load gives no result, so the bench waits SETTLE_CYCLES after the last result before a write.
    task automatic settle_idle();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.set_vertex_count(value);
    endtask

    // Vertices sit on a circle at rising angles, so most polygons are convex and
    // counter-clockwise; some are dented, reversed, given a repeated vertex or scrambled.
    task automatic build_polygon(int n);
        int          order[MAX_VERTICES];
        int          mode;
        int          i;
        int          j;
        int          tmp;
        int          e;
        int unsigned radius;
        longint      t;
        real         phase;
        real         theta;
        center_x = rand_span(134217727);
        center_y = rand_span(134217727);
        e        = $urandom_range(10, 27);
        radius   = $urandom_range(1 << (e - 1), 1 << e);
        phase    = $urandom_range(0, 6283) / 1000.0;
        for (i = 0; i < n; i++) begin
            theta     = phase + TWO_PI * (i + $urandom_range(0, 400) / 1000.0) / n;
            poly_x[i] = center_x + longint'($rtoi(radius * $cos(theta)));
            poly_y[i] = center_y + longint'($rtoi(radius * $sin(theta)));
        end
        mode = $urandom_range(0, 99);
        if (mode >= 94) begin
            for (i = 0; i < n; i++) begin
                poly_x[i] = rand_coord();
                poly_y[i] = rand_coord();
            end
        end else if (mode >= 88) begin
            j             = $urandom_range(0, n - 1);
            poly_x[j]     = poly_x[(j + 1) % n];
            poly_y[j]     = poly_y[(j + 1) % n];
        end else if (mode >= 82) begin
            for (i = 0; i < n / 2; i++) begin
                t                 = poly_x[i];
                poly_x[i]         = poly_x[n - 1 - i];
                poly_x[n - 1 - i] = t;
                t                 = poly_y[i];
                poly_y[i]         = poly_y[n - 1 - i];
                poly_y[n - 1 - i] = t;
            end
        end else if (mode >= 72) begin
            j         = $urandom_range(0, n - 1);
            poly_x[j] = center_x;
            poly_y[j] = center_y;
        end
        for (i = 0; i < n; i++)
            order[i] = i;
        for (i = n - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < n; i++) begin
            send_request(cppl_pkg::OP_LOAD, 6'(order[i]), poly_x[order[i]], poly_y[order[i]]);
            // Stray loads above the vertices in use must not disturb the answers.
            if (n < MAX_VERTICES && $urandom_range(0, 9) == 0)
                send_request(cppl_pkg::OP_LOAD, 6'($urandom_range(n, MAX_VERTICES - 1)),
                             rand_coord(), rand_coord());
        end
    endtask

    task automatic run_queries(int n, int count);
        int     q;
        int     i;
        int     j;
        longint px;
        longint py;
        for (q = 0; q < count; q++) begin
            i = $urandom_range(0, n - 1);
            j = (i + 1) % n;
            case ($urandom_range(0, 5))
                0: begin
                    px = rand_coord();
                    py = rand_coord();
                end
                1: begin
                    px = poly_x[i];
                    py = poly_y[i];
                end
                2: begin
                    px = (poly_x[i] + poly_x[j]) >>> 1;
                    py = (poly_y[i] + poly_y[j]) >>> 1;
                end
                3: begin
                    px = center_x + rand_span(64);
                    py = center_y + rand_span(64);
                end
                4: begin
                    px = poly_x[i] + rand_span(2);
                    py = poly_y[i] + rand_span(2);
                end
                default: begin
                    px = $urandom_range(0, 1) ? C_MAX : C_MIN;
                    py = $urandom_range(0, 1) ? C_MAX : C_MIN;
                end
            endcase
            send_request(cppl_pkg::OP_QUERY, 6'($urandom), px, py);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_location_valid !== 1'b0)
            sb.check_location(o_location);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("convex_polygon_point_location_test: done, errors");
        $finish;
    end

    initial begin
        int phase;
        int n;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Vertex count is still at its reset value: a triangle spanning the coordinate range.
        send_request(cppl_pkg::OP_LOAD, 6'd0, C_MIN, C_MIN);
        send_request(cppl_pkg::OP_LOAD, 6'd1, C_MAX, C_MIN);
        send_request(cppl_pkg::OP_LOAD, 6'd2, C_MIN, C_MAX);
        send_request(cppl_pkg::OP_LOAD, 6'd63, C_MAX, C_MAX);
        send_request(cppl_pkg::OP_QUERY, 6'd63, C_MAX, C_MAX);
        send_request(cppl_pkg::OP_QUERY, 6'd0, C_MIN, C_MIN);
        send_request(cppl_pkg::OP_QUERY, 6'd0, 0, -1);
        send_request(cppl_pkg::OP_QUERY, 6'd0, -1000, -1000);
        send_request(cppl_pkg::OP_QUERY, 6'd0, C_MIN, 0);
        // Same triangle listed clockwise.
        send_request(cppl_pkg::OP_LOAD, 6'd1, C_MIN, C_MAX);
        send_request(cppl_pkg::OP_LOAD, 6'd2, C_MAX, C_MIN);
        send_request(cppl_pkg::OP_QUERY, 6'd0, 0, 0);
        // Three collinear vertices: one of them lies on the segment of another edge.
        send_request(cppl_pkg::OP_LOAD, 6'd0, 0, 0);
        send_request(cppl_pkg::OP_LOAD, 6'd1, 256, 0);
        send_request(cppl_pkg::OP_LOAD, 6'd2, 512, 0);
        send_request(cppl_pkg::OP_QUERY, 6'd0, 256, 0);

        // A square with an extra vertex mid-side: collinear but off the segment, still convex.
        settle_idle();
        write_vertex_count(7'd5);
        send_request(cppl_pkg::OP_LOAD, 6'd0, 0, 0);
        send_request(cppl_pkg::OP_LOAD, 6'd1, 512, 0);
        send_request(cppl_pkg::OP_LOAD, 6'd2, 1024, 0);
        send_request(cppl_pkg::OP_LOAD, 6'd3, 1024, 1024);
        send_request(cppl_pkg::OP_LOAD, 6'd4, 0, 1024);
        send_request(cppl_pkg::OP_QUERY, 6'd0, 512, 512);
        send_request(cppl_pkg::OP_QUERY, 6'd0, 256, 0);
        send_request(cppl_pkg::OP_QUERY, 6'd0, 512, 0);
        send_request(cppl_pkg::OP_QUERY, 6'd0, 2000, 0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle_idle();
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 30;
                default: idle_pct = 60;
            endcase
            write_vertex_count(choose_count(phase));
            n = sb.used_vertices();
            build_polygon(n);
            run_queries(n, $urandom_range(3, 12));
            phase++;
        end

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("convex_polygon_point_location_test: done, clean");
        else
            $display("convex_polygon_point_location_test: done, errors");
        $finish;
    end

endmodule
